>>> src/life_automaton_grid_assert.svh
// Assertion macros shared by the life grid modules.
`ifndef LIFE_AUTOMATON_GRID_ASSERT_SVH
`define LIFE_AUTOMATON_GRID_ASSERT_SVH

// Same-cycle implication, sampled on aclk, switched off while aresetn is low.
`define LAG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("life grid check failed");

// Next-cycle implication, sampled on aclk, switched off while aresetn is low.
`define LAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("life grid check failed");

`endif

>>> src/lag_pkg.sv
// Shared types, constants and the B3/S23 rule for the life grid.
package lag_pkg;

    localparam int LAG_MAX_ROWS = 64;
    localparam int LAG_MAX_COLS = 64;

    localparam int LAG_OP_W    = 2;
    localparam int LAG_IDX_W   = 6;
    localparam int LAG_CFG_W   = 7;
    localparam int LAG_CFG_IDX_W = 1;
    localparam int LAG_COUNT_W = 4;

    localparam logic [LAG_COUNT_W-1:0] LAG_SURVIVE = LAG_COUNT_W'(2);
    localparam logic [LAG_COUNT_W-1:0] LAG_BIRTH   = LAG_COUNT_W'(3);
    localparam int LAG_NEIGHBOURS = 8;

    typedef enum logic [LAG_OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2
    } lag_op_t;

    typedef enum logic [LAG_CFG_IDX_W-1:0] {
        CFG_ROWS_IN_USE = 1'b0,
        CFG_COLS_IN_USE = 1'b1
    } lag_cfg_idx_t;

    // Control broadcast from the top level to every row cell.
    typedef struct packed {
        logic write_en;
        logic step_en;
        logic new_value;
    } lag_ctrl_t;

    // Next state of one cell from its own value and its live neighbour count.
    function automatic logic lag_rule(input logic alive, input logic [LAG_COUNT_W-1:0] count);
        return (count == LAG_BIRTH) || (alive && (count == LAG_SURVIVE));
    endfunction

endpackage

>>> src/life_automaton_grid.sv
// Top level of the bounded Game of Life grid (rule B3/S23) built as a chain of row cells.
//
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+-------------------------------------------
//  s_        | in        | s_valid / s_ready | s_operation, s_row, s_col, s_new_value
//  m_        | out       | m_valid / m_ready | m_cell_alive, m_in_range
//  cfg_      | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
// Each item, whether a write, a read or a whole generation, is applied at the
// edge that accepts it, because each row cell updates its own row from its two
// neighbours in parallel. The result goes into a single output register, so a new item
// is accepted whenever that register is empty or being emptied in the same cycle.
// A stall on the result side therefore holds back the input side only while a result
// is waiting. Reset is synchronous and clears the whole grid; there is no
// clearing pass, and both size registers return to the full grid.
module life_automaton_grid #(
    parameter int MAX_ROWS = lag_pkg::LAG_MAX_ROWS,
    parameter int MAX_COLS = lag_pkg::LAG_MAX_COLS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lag_pkg::LAG_OP_W-1:0]       s_operation,
    input  logic [lag_pkg::LAG_IDX_W-1:0]      s_row,
    input  logic [lag_pkg::LAG_IDX_W-1:0]      s_col,
    input  logic                               s_new_value,
    // result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_cell_alive,
    output logic                               m_in_range,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [lag_pkg::LAG_CFG_IDX_W-1:0]  cfg_index,
    input  logic [lag_pkg::LAG_CFG_W-1:0]      cfg_wdata
);
    import lag_pkg::*;

    `include "life_automaton_grid_assert.svh"

    logic [LAG_CFG_W-1:0]  rows_in_use_reg;
    logic [LAG_CFG_W-1:0]  cols_in_use_reg;
    logic                  m_valid_reg;
    logic                  m_cell_alive_reg;
    logic                  m_in_range_reg;

    logic                  accept;
    logic                  in_region;
    logic                  rd_any;
    lag_op_t               op;
    lag_ctrl_t             ctrl;
    logic [MAX_COLS-1:0]   col_mask;
    logic [MAX_COLS-1:0]   col_onehot;
    logic [MAX_COLS-1:0]   nbr_rows [MAX_ROWS];
    logic [MAX_ROWS-1:0]   rd_bits;

    // The output register frees up in the same cycle in which its result is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign op      = lag_op_t'(s_operation);

    // A size register above the grid saturates: the grid bounds cut the region as well.
    assign in_region = ({1'b0, s_row} < rows_in_use_reg) && (32'(s_row) < 32'(MAX_ROWS))
                    && ({1'b0, s_col} < cols_in_use_reg) && (32'(s_col) < 32'(MAX_COLS));

    // Column masks are shared by all the row cells.
    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            col_mask[c]   = 32'(cols_in_use_reg) > 32'(c);
            col_onehot[c] = 32'(s_col) == 32'(c);
        end
    end

    always_comb begin
        ctrl.write_en  = accept && (op == OP_WRITE) && in_region;
        ctrl.step_en   = accept && (op == OP_STEP);
        ctrl.new_value = s_new_value;
    end

    // The chain of row cells: each one sees the masked rows directly above and below it,
    // and the rows past the top and bottom edges are tied to dead cells.
    for (genvar i = 0; i < MAX_ROWS; i++) begin : g_row
        logic [MAX_COLS-1:0] up_row;
        logic [MAX_COLS-1:0] down_row;

        if (i == 0) begin : g_first
            assign up_row = '0;
        end else begin : g_inner_up
            assign up_row = nbr_rows[i-1];
        end

        if (i == MAX_ROWS - 1) begin : g_last
            assign down_row = '0;
        end else begin : g_inner_down
            assign down_row = nbr_rows[i+1];
        end

        lag_row_cell #(
            .NUM_COLS (MAX_COLS),
            .ROW_IDX  (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .row_sel     (s_row),
            .rows_in_use (rows_in_use_reg),
            .col_mask    (col_mask),
            .col_onehot  (col_onehot),
            .up_row      (up_row),
            .down_row    (down_row),
            .nbr_row     (nbr_rows[i]),
            .rd_bit      (rd_bits[i])
        );
    end

    // Only the addressed cell can raise its read bit, so an OR gathers the read data.
    assign rd_any = |rd_bits;

    // Configuration: a write to an index past the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_in_use_reg <= LAG_CFG_W'(64);
            cols_in_use_reg <= LAG_CFG_W'(64);
        end else if (cfg_wr_en) begin
            unique case (lag_cfg_idx_t'(cfg_index))
                CFG_ROWS_IN_USE: rows_in_use_reg <= cfg_wdata;
                CFG_COLS_IN_USE: cols_in_use_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Result register. A step and the unused operation code report zero in both fields.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            m_cell_alive_reg <= 1'b0;
            m_in_range_reg   <= 1'b0;
        end else begin
            priority if (accept) begin
                m_valid_reg <= 1'b1;
                unique case (op)
                    OP_WRITE: begin
                        m_cell_alive_reg <= 1'b0;
                        m_in_range_reg   <= in_region;
                    end
                    OP_READ: begin
                        m_cell_alive_reg <= in_region && rd_any;
                        m_in_range_reg   <= in_region;
                    end
                    default: begin
                        m_cell_alive_reg <= 1'b0;
                        m_in_range_reg   <= 1'b0;
                    end
                endcase
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= m_valid_reg;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_alive = m_cell_alive_reg;
    assign m_in_range   = m_in_range_reg;

    `LAG_ASSERT_NEXT(a_accept_gives_result, accept, m_valid_reg)
    `LAG_ASSERT_NEXT(a_step_result_zero, accept && (op == OP_STEP), !m_cell_alive_reg && !m_in_range_reg)
    `LAG_ASSERT_NOW(a_alive_only_in_range, m_valid_reg && m_cell_alive_reg, m_in_range_reg)

endmodule

>>> src/lag_row_cell.sv
// One row of the life grid: holds the row, exchanges it with its neighbours, updates it.
module lag_row_cell #(
    parameter int NUM_COLS = lag_pkg::LAG_MAX_COLS,
    parameter int ROW_IDX  = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lag_pkg::lag_ctrl_t              ctrl,
    input  logic [lag_pkg::LAG_IDX_W-1:0]   row_sel,
    input  logic [lag_pkg::LAG_CFG_W-1:0]   rows_in_use,
    input  logic [NUM_COLS-1:0]             col_mask,
    input  logic [NUM_COLS-1:0]             col_onehot,
    input  logic [NUM_COLS-1:0]             up_row,
    input  logic [NUM_COLS-1:0]             down_row,
    output logic [NUM_COLS-1:0]             nbr_row,
    output logic                            rd_bit
);
    import lag_pkg::*;

    `include "life_automaton_grid_assert.svh"

    logic [NUM_COLS-1:0]   row_reg;
    logic [NUM_COLS-1:0]   row_next;
    logic [NUM_COLS-1:0]   step_row;
    logic [NUM_COLS+1:0]   up_pad;
    logic [NUM_COLS+1:0]   own_pad;
    logic [NUM_COLS+1:0]   down_pad;
    logic                  active;
    logic                  row_hit;

    assign active  = 32'(rows_in_use) > 32'(ROW_IDX);
    assign row_hit = 32'(row_sel) == 32'(ROW_IDX);

    // Cells outside the region in use look dead to the rows around them.
    assign nbr_row = active ? (row_reg & col_mask) : '0;
    assign rd_bit  = row_hit && (|(row_reg & col_onehot));

    // A zero column on each side stands for the dead cells beyond the edge.
    assign up_pad   = {1'b0, up_row, 1'b0};
    assign own_pad  = {1'b0, nbr_row, 1'b0};
    assign down_pad = {1'b0, down_row, 1'b0};

    always_comb begin
        logic [LAG_COUNT_W-1:0] count;
        count    = '0;
        step_row = row_reg;
        for (int c = 0; c < NUM_COLS; c++) begin
            count = LAG_COUNT_W'(up_pad[c]) + LAG_COUNT_W'(up_pad[c+1])
                  + LAG_COUNT_W'(up_pad[c+2]) + LAG_COUNT_W'(own_pad[c])
                  + LAG_COUNT_W'(own_pad[c+2]) + LAG_COUNT_W'(down_pad[c])
                  + LAG_COUNT_W'(down_pad[c+1]) + LAG_COUNT_W'(down_pad[c+2]);
            if (col_mask[c]) begin
                step_row[c] = lag_rule(row_reg[c], count);
            end
        end
    end

    always_comb begin
        row_next = row_reg;
        priority if (ctrl.step_en && active) begin
            row_next = step_row;
        end else if (ctrl.write_en && row_hit) begin
            row_next = (row_reg & ~col_onehot) | (col_onehot & {NUM_COLS{ctrl.new_value}});
        end else begin
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_next;
        end
    end

    `LAG_ASSERT_NEXT(a_idle_row_holds, !active, $stable(row_reg))
    `LAG_ASSERT_NEXT(a_untouched_row_holds, !ctrl.step_en && !(ctrl.write_en && row_hit), $stable(row_reg))
    `LAG_ASSERT_NEXT(a_write_one_cell, ctrl.write_en && row_hit && !ctrl.step_en, $countones(row_reg ^ $past(row_reg)) <= 1)

endmodule
